@@ rtl/u8u16_pkg.sv @@
package u8u16_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW = $clog2(QueueDepth);
   localparam int QueueLevelW = $clog2(QueueDepth + 1);
   localparam int MaxUnits = 3;

   localparam logic [15:0] UnitLimitReset = 16'd128;
   localparam logic [15:0] SurrHigh = 16'hD800;
   localparam logic [15:0] SurrLow = 16'hDC00;
   localparam logic [31:0] PlaneOne = 32'h0001_0000;
   localparam logic [31:0] CodeMax = 32'h0010_FFFF;
   localparam logic [10:0] PlaneBias = 11'h040;

   typedef struct packed {
      logic [MaxUnits-1:0][15:0] units;
      logic [1:0]                num;
      logic [15:0]               base_count;
      logic                      closes;
   } entry_type;

endpackage

@@ rtl/u8u16_if.sv @@
interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_in_string;

   modport source(output valid, output byte_in, output last_in_string, input ready);
   modport sink(input valid, input byte_in, input last_in_string, output ready);
endinterface

interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] unit;
   logic        run_last;
   logic        string_end;
   logic [15:0] unit_count;

   modport source(output valid, output unit, output run_last, output string_end,
                  output unit_count, input ready);
   modport sink(input valid, input unit, input run_last, input string_end,
                input unit_count, output ready);
endinterface

@@ rtl/u8u16_front.sv @@
module u8u16_front import u8u16_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   u8u16_req_if.sink   req,
   input  logic        full,
   output logic        push,
   output entry_type   push_entry,
   output logic [15:0] unit_limit
);

   typedef struct packed {
      logic        two;
      logic [15:0] first;
      logic [15:0] second;
   } split_type;

   function automatic split_type split_value(input logic [31:0] v);
      split_type s;
      s.two = (v >= PlaneOne) && (v <= CodeMax);
      if (s.two) begin
         s.first = SurrHigh | {6'd0, 10'(v[20:10] - PlaneBias)};
         s.second = SurrLow | {6'd0, v[9:0]};
      end else begin
         s.first = v[15:0];
         s.second = 16'd0;
      end
      return s;
   endfunction

   logic [31:0] code_ff, code_in;
   logic [2:0]  pending_ff, pending_in;
   logic [15:0] emitted_ff, emitted_in;
   logic [15:0] limit_ff, limit_in;

   logic [7:0]  b;
   logic        last;
   logic        accept;
   logic [31:0] cv_step;
   logic [2:0]  pc_step;
   logic        have_a, have_b;
   logic [31:0] val_a, val_b;
   split_type   ua, ub;
   logic [1:0]  na, nb;
   logic [2:0]  total;
   logic [1:0]  ntot;
   logic [15:0] room;
   logic [1:0]  keep;
   logic [MaxUnits-1:0][15:0] lst;

   assign b = req.byte_in;
   assign last = req.last_in_string;
   assign req.ready = !full;
   assign accept = req.valid && !full;
   assign unit_limit = limit_ff;

   always_comb begin
      cv_step = code_ff;
      pc_step = 3'd0;
      have_a = 1'b0;
      have_b = 1'b0;
      val_a = code_ff;
      val_b = code_ff;
      if (pending_ff != 3'd0 && b[7:6] == 2'b10) begin
         cv_step = {code_ff[25:0], b[5:0]};
         pc_step = pending_ff - 3'd1;
         have_a = (pc_step == 3'd0) || last;
         val_a = cv_step;
      end else begin
         have_a = pending_ff != 3'd0;
         if (b[7] == 1'b0) begin
            cv_step = {24'd0, b};
            have_b = 1'b1;
         end else if (b[7:5] == 3'b110) begin
            cv_step = {27'd0, b[4:0]};
            pc_step = 3'd1;
            have_b = last;
         end else if (b[7:4] == 4'b1110) begin
            cv_step = {28'd0, b[3:0]};
            pc_step = 3'd2;
            have_b = last;
         end else if (b[7:3] == 5'b11110) begin
            cv_step = {29'd0, b[2:0]};
            pc_step = 3'd3;
            have_b = last;
         end else if (b[7:2] == 6'b111110) begin
            cv_step = {30'd0, b[1:0]};
            pc_step = 3'd4;
            have_b = last;
         end else if (b[7:1] == 7'b1111110) begin
            cv_step = {31'd0, b[0]};
            pc_step = 3'd5;
            have_b = last;
         end else begin
            have_b = 1'b1;
         end
         val_b = cv_step;
      end
   end

   always_comb begin
      ua = split_value(val_a);
      ub = split_value(val_b);
      na = have_a ? (ua.two ? 2'd2 : 2'd1) : 2'd0;
      nb = have_b ? (ub.two ? 2'd2 : 2'd1) : 2'd0;
      total = {1'b0, na} + {1'b0, nb};
      ntot = (total > 3'd3) ? 2'd3 : total[1:0];
      case (na)
         2'd1: lst = {ub.second, ub.first, ua.first};
         2'd2: lst = {ub.first, ua.second, ua.first};
         default: lst = {16'd0, ub.second, ub.first};
      endcase
      room = (emitted_ff < limit_ff) ? (limit_ff - emitted_ff) : 16'd0;
      keep = ({14'd0, ntot} > room) ? room[1:0] : ntot;
   end

   assign push = accept && (keep != 2'd0);
   assign push_entry.units = lst;
   assign push_entry.num = keep;
   assign push_entry.base_count = emitted_ff;
   assign push_entry.closes = last;

   always_comb begin
      code_in = code_ff;
      pending_in = pending_ff;
      emitted_in = emitted_ff;
      limit_in = csr_write_enable ? csr_write_data : limit_ff;
      if (accept) begin
         code_in = last ? 32'd0 : cv_step;
         pending_in = last ? 3'd0 : pc_step;
         emitted_in = last ? 16'd0 : emitted_ff + {14'd0, keep};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= 32'd0;
         pending_ff <= 3'd0;
         emitted_ff <= 16'd0;
         limit_ff <= UnitLimitReset;
      end else begin
         code_ff <= code_in;
         pending_ff <= pending_in;
         emitted_ff <= emitted_in;
         limit_ff <= limit_in;
      end
   end

endmodule

@@ rtl/u8u16_queue.sv @@
module u8u16_queue import u8u16_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  entry_type              push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output entry_type              head_entry,
   output logic [QueueLevelW-1:0] level
);

   entry_type mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueLevelW-1:0] level_ff, level_in;
   logic                   do_push, do_pop;

   assign full = level_ff == QueueLevelW'(QueueDepth);
   assign head_valid = level_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];
   assign level = level_ff;
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      level_in = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + QueueLevelW'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - QueueLevelW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
      end
   end

endmodule

@@ rtl/u8u16_back.sv @@
module u8u16_back import u8u16_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   u8u16_rsp_if.source rsp
);

   logic [1:0] idx_ff, idx_in;
   logic       at_end;
   logic       transfer;

   assign at_end = idx_ff == (head_entry.num - 2'd1);
   assign transfer = head_valid && rsp.ready;
   assign pop = transfer && at_end;

   assign rsp.valid = head_valid;
   assign rsp.unit = head_entry.units[idx_ff];
   assign rsp.run_last = at_end;
   assign rsp.string_end = at_end && head_entry.closes;
   assign rsp.unit_count = head_entry.base_count + {14'd0, idx_ff} + 16'd1;

   always_comb begin
      idx_in = idx_ff;
      if (transfer) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

@@ rtl/utf8_to_utf16_stream_unit.sv @@
// UTF-8 to UTF-16 stream converter.
// The req_chan channel takes one UTF-8 byte per transfer together with a flag
// that marks the final byte of a string. The rsp_chan channel delivers UTF-16
// code units, each with run_last on the final unit caused by its byte,
// string_end on the final unit of a string, and the running unit count.
// The csr port writes the per-string unit limit; units past it are dropped.
// A byte is decoded in the cycle it is taken, and its units go into one queue
// entry whose head drives rsp_chan. The decoder takes one byte per cycle while
// the four-entry queue between decoder and output has room; the output side
// sends one unit per cycle while the receiver is ready, so a byte that yields
// two or three units holds the output while the queue absorbs later bytes.
// When the receiver stalls, the queue fills and req_chan.ready drops until
// an entry drains. Reset empties the queue, clears the decoder state and
// sets the unit limit to 128; no clearing pass is needed.
module utf8_to_utf16_stream_unit import u8u16_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   u8u16_req_if.sink   req_chan,
   u8u16_rsp_if.source rsp_chan
);

   logic                   push;
   entry_type              push_entry;
   logic                   full;
   logic                   pop;
   logic                   head_valid;
   entry_type              head_entry;
   logic [QueueLevelW-1:0] level;
   logic [15:0]            unit_limit;

   u8u16_front front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_chan),
      .full             (full),
      .push             (push),
      .push_entry       (push_entry),
      .unit_limit       (unit_limit)
   );

   u8u16_queue queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .level      (level)
   );

   u8u16_back back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      level <= QueueLevelW'(QueueDepth))
      else $error("queue level beyond its depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.run_last |=> rsp_chan.valid)
      else $error("unit burst broken before its last unit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.unit_count != 16'd0
         && rsp_chan.unit_count <= unit_limit)
      else $error("unit count outside the limit");

   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("entry pushed into a full queue");
`endif

endmodule

@@ test/u8u16_stream_checker.sv @@
`timescale 1ns / 1ps
module u8u16_stream_checker import u8u16_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   u8u16_req_if        req_mon,
   u8u16_rsp_if        rsp_mon,
   output int          failures,
   output int          pending_units
);

   typedef struct packed {
      logic [15:0] unit;
      logic        run_last;
      logic        string_end;
      logic [15:0] unit_count;
   } utf16_unit_type;

   localparam int ReportLimit = 10;

   logic [31:0]    code_value;
   logic [2:0]     continuations_due;
   logic [15:0]    units_emitted;
   logic [15:0]    unit_limit;
   utf16_unit_type expected_units[$];
   utf16_unit_type byte_units[$];
   utf16_unit_type observed;
   int             mismatches = 0;

   task automatic emit_unit(input logic [31:0] value);
      utf16_unit_type rec;
      if (byte_units.size() < MaxUnits && units_emitted < unit_limit) begin
         units_emitted = units_emitted + 16'd1;
         rec.unit = value[15:0];
         rec.run_last = 1'b0;
         rec.string_end = 1'b0;
         rec.unit_count = units_emitted;
         byte_units.push_back(rec);
      end
   endtask

   task automatic emit_value(input logic [31:0] value);
      logic [31:0] plane;
      if (value >= PlaneOne && value <= CodeMax) begin
         plane = ((value & 32'h001F_FC00) >> 10) - {21'd0, PlaneBias};
         emit_unit({16'd0, SurrHigh} | plane);
         emit_unit({16'd0, SurrLow} | (value & 32'h0000_03FF));
      end else begin
         emit_unit(value);
      end
   endtask

   task automatic start_sequence(input logic [7:0] b);
      casez (b)
         8'b0???_????: begin
            code_value = {24'd0, b};
            continuations_due = 3'd0;
            emit_value(code_value);
         end
         8'b110?_????: begin
            code_value = {27'd0, b[4:0]};
            continuations_due = 3'd1;
         end
         8'b1110_????: begin
            code_value = {28'd0, b[3:0]};
            continuations_due = 3'd2;
         end
         8'b1111_0???: begin
            code_value = {29'd0, b[2:0]};
            continuations_due = 3'd3;
         end
         8'b1111_10??: begin
            code_value = {30'd0, b[1:0]};
            continuations_due = 3'd4;
         end
         8'b1111_110?: begin
            code_value = {31'd0, b[0]};
            continuations_due = 3'd5;
         end
         default: begin
            emit_value(code_value);
         end
      endcase
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      utf16_unit_type closing;
      byte_units.delete();
      if (continuations_due != 3'd0) begin
         if (b[7:6] == 2'b10) begin
            code_value = {code_value[25:0], b[5:0]};
            continuations_due = continuations_due - 3'd1;
            if (continuations_due == 3'd0) begin
               emit_value(code_value);
            end
         end else begin
            emit_value(code_value);
            continuations_due = 3'd0;
            start_sequence(b);
         end
      end else begin
         start_sequence(b);
      end
      if (last && continuations_due != 3'd0) begin
         emit_value(code_value);
         continuations_due = 3'd0;
      end
      if (byte_units.size() > 0) begin
         closing = byte_units.pop_back();
         closing.run_last = 1'b1;
         closing.string_end = last;
         byte_units.push_back(closing);
      end
      foreach (byte_units[i]) begin
         expected_units.push_back(byte_units[i]);
      end
      if (last) begin
         code_value = 32'd0;
         continuations_due = 3'd0;
         units_emitted = 16'd0;
      end
   endtask

   task automatic check_unit(input utf16_unit_type got);
      utf16_unit_type want;
      if (expected_units.size() == 0) begin
         mismatches++;
         if (mismatches <= ReportLimit) begin
            $display("%0t: unexpected transfer unit=%h run_last=%b string_end=%b count=%0d",
                     $realtime, got.unit, got.run_last, got.string_end, got.unit_count);
         end
      end else begin
         want = expected_units.pop_front();
         if (got.unit !== want.unit || got.run_last !== want.run_last ||
             got.string_end !== want.string_end || got.unit_count !== want.unit_count) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("%0t: expected unit=%h run_last=%b string_end=%b count=%0d",
                        $realtime, want.unit, want.run_last, want.string_end,
                        want.unit_count);
               $display("%0t:   actual unit=%h run_last=%b string_end=%b count=%0d",
                        $realtime, got.unit, got.run_last, got.string_end, got.unit_count);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         code_value = 32'd0;
         continuations_due = 3'd0;
         units_emitted = 16'd0;
         unit_limit = UnitLimitReset;
         expected_units.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed.unit = rsp_mon.unit;
            observed.run_last = rsp_mon.run_last;
            observed.string_end = rsp_mon.string_end;
            observed.unit_count = rsp_mon.unit_count;
            check_unit(observed);
         end
         if (req_mon.valid && req_mon.ready) begin
            decode_byte(req_mon.byte_in, req_mon.last_in_string);
         end
         if (csr_write_enable) begin
            unit_limit = csr_write_data;
         end
      end
      failures <= mismatches;
      pending_units <= expected_units.size();
   end

endmodule

@@ test/tb_utf8_to_utf16_stream_unit.sv @@
`timescale 1ns / 1ps
module tb_utf8_to_utf16_stream_unit;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;
   int          failures;
   int          pending_units;
   bit          quiet_stretch = 1'b0;
   bit          hold_off_request = 1'b0;
   logic [7:0]  string_bytes[$];

   u8u16_req_if req_chan();
   u8u16_rsp_if rsp_chan();

   utf8_to_utf16_stream_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   u8u16_stream_checker unit_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .failures         (failures),
      .pending_units    (pending_units)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = quiet_stretch ? 0 : $urandom_range(13, 0);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.byte_in <= b;
      req_chan.last_in_string <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_string();
      int count;
      count = string_bytes.size();
      for (int i = 0; i < count; i++) begin
         send_byte(string_bytes[i], i == count - 1);
      end
      string_bytes.delete();
   endtask

   // Lowers valid right after the final transfer, then waits for the block to go idle.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_units != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_unit_limit(input logic [15:0] limit);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic append_random_char();
      int pick;
      int form;
      int keep;
      logic [7:0] lead;
      pick = $urandom_range(99, 0);
      form = 0;
      if (pick < 6) begin
         string_bytes.push_back(8'($urandom));
      end else if (pick < 10) begin
         case ($urandom_range(2, 0))
            0: string_bytes.push_back(8'hFE);
            1: string_bytes.push_back(8'hFF);
            default: string_bytes.push_back({2'b10, 6'($urandom)});
         endcase
      end else if (pick < 40) begin
         string_bytes.push_back({1'b0, 7'($urandom)});
      end else if (pick < 60) begin
         form = 2;
         lead = {3'b110, 5'($urandom)};
      end else if (pick < 75) begin
         form = 3;
         lead = {4'b1110, 4'($urandom)};
      end else if (pick < 92) begin
         form = 4;
         lead = {5'b11110, 3'($urandom)};
      end else if (pick < 96) begin
         form = 5;
         lead = {6'b111110, 2'($urandom)};
      end else begin
         form = 6;
         lead = {7'b1111110, 1'($urandom)};
      end
      if (form > 0) begin
         keep = form - 1;
         if ($urandom_range(9, 0) == 0) begin
            keep = $urandom_range(form - 1, 0);
         end
         string_bytes.push_back(lead);
         repeat (keep) string_bytes.push_back({2'b10, 6'($urandom)});
      end
   endtask

   task automatic run_phase(input logic [15:0] limit, input int byte_budget,
                            input int max_chars);
      int sent;
      write_unit_limit(limit);
      sent = 0;
      while (sent < byte_budget) begin
         quiet_stretch = ($urandom_range(4, 0) == 0);
         repeat ($urandom_range(max_chars, 1)) append_random_char();
         sent += string_bytes.size();
         send_string();
      end
      quiet_stretch = 1'b0;
   endtask

   initial begin
      int stall;
      forever begin
         if (hold_off_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off_request = 1'b0;
         end
         stall = quiet_stretch ? 0 : $urandom_range(13, 0);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 16'd0;
      req_chan.valid = 1'b0;
      req_chan.byte_in = 8'd0;
      req_chan.last_in_string = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      string_bytes = '{8'h80, 8'h41, 8'h00};
      send_string();
      string_bytes = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
      send_string();
      string_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hFF, 8'hE2, 8'h82, 8'h41};
      send_string();
      // A flushed partial pair followed by a re-emit overflows the three-unit burst.
      string_bytes = '{8'hF9, 8'h80, 8'h80, 8'h80, 8'hFE, 8'hFD, 8'h80};
      send_string();

      write_unit_limit(16'd1);
      string_bytes = '{8'h41, 8'h42, 8'h43};
      send_string();
      string_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};
      send_string();

      write_unit_limit(16'hFFFF);
      hold_off_request = 1'b1;
      quiet_stretch = 1'b1;
      repeat (40) string_bytes.push_back({1'b0, 7'($urandom)});
      send_string();
      quiet_stretch = 1'b0;

      run_phase(16'hFFFF, 150, 12);
      run_phase(16'd3, 50, 6);
      run_phase(16'($urandom_range(30, 4)), 120, 30);
      run_phase(16'd2, 30, 4);
      run_phase(16'd128, 120, 12);

      drain_results();
      if (failures == 0 && pending_units == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
